@@ rtl/pressure_sensor_compensation_assert.svh @@
// Assertion macros shared by the pressure compensation RTL
`ifndef PRESSURE_SENSOR_COMPENSATION_ASSERT_SVH
`define PRESSURE_SENSOR_COMPENSATION_ASSERT_SVH

// same-cycle implication, masked during reset
`define PSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, masked during reset
`define PSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// check of the cycle that follows a reset
`define PSC_ASSERT_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("reset check failed");

`endif

@@ rtl/psc_pkg.sv @@
// Types and constants shared by the pressure compensation pipeline
`timescale 1ns / 1ps
package psc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int TEMP_BASE       = 2000;
   // 2000 + 1500: very-low threshold expressed relative to the first-order deviation
   localparam int VERY_LOW_OFFSET = 3500;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODEL_SELECT      = 3'd0,
      CSR_PRESSURE_SENS     = 3'd1,
      CSR_PRESSURE_OFFSET   = 3'd2,
      CSR_SENS_TEMP_COEFF   = 3'd3,
      CSR_OFFSET_TEMP_COEFF = 3'd4,
      CSR_REFERENCE_TEMP    = 3'd5,
      CSR_TEMP_COEFF        = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic        model_select;
      logic [15:0] pressure_sens;
      logic [15:0] pressure_offset;
      logic [15:0] sens_temp_coeff;
      logic [15:0] offset_temp_coeff;
      logic [15:0] reference_temp;
      logic [15:0] temp_coeff;
   } cfg_type;

   typedef struct packed {
      logic [23:0] raw_pressure;
      logic [23:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pressure;
      logic signed [31:0] temperature;
   } rsp_type;

   // first-order results leaving the front end
   typedef struct packed {
      logic [23:0]        d1;
      logic signed [39:0] sens1;
      logic signed [39:0] off1;
      logic signed [19:0] dev;
      logic signed [19:0] lo;
      logic [19:0]        ti_low;
      logic [19:0]        ti_high;
   } front_type;

   // corrected sensitivity, offset and final temperature
   typedef struct packed {
      logic [23:0]        d1;
      logic signed [39:0] sens;
      logic signed [39:0] off;
      logic signed [31:0] temp;
   } corr_type;

endpackage

@@ rtl/pressure_sensor_compensation.sv @@
// Top level: calibration registers, pipeline stall control and stage chain
//
//   channel | direction | transfer when          | payload
//   req     | in        | req_valid & !req_stall | req_data (raw pressure, raw temperature)
//   rsp     | out       | rsp_valid & !rsp_stall | rsp_data (pressure, temperature)
//   csr     | in        | csr_valid & csr_ready  | csr_index, csr_wdata
//
// One item per cycle unless a held result stalls the pipeline. Each item passes nine
// register stages: those of the front, correction and back-end sections.
// Synchronous reset empties the pipeline and clears all calibration words.
// A held result with rsp_stall high freezes every stage and raises req_stall.
`timescale 1ns / 1ps
`include "pressure_sensor_compensation_assert.svh"
module pressure_sensor_compensation
   import psc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type   cfg_ff;
   logic      advance;
   logic      front_valid, second_valid;
   front_type front_data;
   corr_type  second_data;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODEL_SELECT:      cfg_ff.model_select      <= csr_wdata[0];
            CSR_PRESSURE_SENS:     cfg_ff.pressure_sens     <= csr_wdata;
            CSR_PRESSURE_OFFSET:   cfg_ff.pressure_offset   <= csr_wdata;
            CSR_SENS_TEMP_COEFF:   cfg_ff.sens_temp_coeff   <= csr_wdata;
            CSR_OFFSET_TEMP_COEFF: cfg_ff.offset_temp_coeff <= csr_wdata;
            CSR_REFERENCE_TEMP:    cfg_ff.reference_temp    <= csr_wdata;
            CSR_TEMP_COEFF:        cfg_ff.temp_coeff        <= csr_wdata;
            default:               cfg_ff                   <= cfg_ff;
         endcase
      end
   end

   psc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   psc_second u_second (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (second_valid),
      .out_data  (second_data)
   );

   psc_pressure u_pressure (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cfg       (cfg_ff),
      .in_valid  (second_valid),
      .in_data   (second_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   // pipeline is empty straight after reset
   `PSC_ASSERT_RESET(empty_after_reset_a, clock, reset, !rsp_valid)
   // a transfer in reaches the output when no stall intervenes
   `PSC_ASSERT_NEXT(latency_a, clock, reset, (req_valid && !req_stall) ##1 !req_stall ##1 !req_stall ##1 !req_stall ##1 !req_stall ##1 !req_stall ##1 !req_stall ##1 !req_stall ##1 !req_stall, rsp_valid)

endmodule

@@ rtl/psc_front.sv @@
// Front end: temperature difference, coefficient products and first-order terms
`timescale 1ns / 1ps
module psc_front
   import psc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  cfg_type   cfg,
   input  logic      in_valid,
   input  req_type   in_data,
   output logic      out_valid,
   output front_type out_data
);

   // stage 1
   logic               s1_valid_ff, s1_valid_in;
   logic [23:0]        s1_d1_ff, s1_d1_in;
   logic signed [25:0] s1_dt_ff, s1_dt_in;
   // stage 2
   logic               s2_valid_ff;
   logic [23:0]        s2_d1_ff;
   logic signed [42:0] s2_p3_ff, s2_p3_in;
   logic signed [42:0] s2_p4_ff, s2_p4_in;
   logic signed [42:0] s2_p6_ff, s2_p6_in;
   logic signed [51:0] s2_sq_ff, s2_sq_in;
   // stage 3
   logic               s3_valid_ff;
   front_type          s3_ff, s3_in;

   logic [7:0]         p3_round, p4_round;
   logic [22:0]        p6_round;
   logic signed [42:0] p3_adj, p4_adj, p6_adj, q3, q4;
   logic [55:0]        sq_w, sq_x11, sq_x3;

   assign s1_valid_in = in_valid;
   assign s1_d1_in    = in_data.raw_pressure;
   assign s1_dt_in    = $signed({2'd0, in_data.raw_temperature})
                      - $signed({2'd0, cfg.reference_temp, 8'd0});

   assign s2_p3_in = $signed({1'b0, cfg.sens_temp_coeff}) * s1_dt_ff;
   assign s2_p4_in = $signed({1'b0, cfg.offset_temp_coeff}) * s1_dt_ff;
   assign s2_p6_in = $signed({1'b0, cfg.temp_coeff}) * s1_dt_ff;
   assign s2_sq_in = s1_dt_ff * s1_dt_ff;

   // truncation toward zero: bias negative values before the arithmetic shift
   always_comb begin
      p3_round = 8'd0;
      p4_round = 8'd0;
      if (s2_p3_ff[42]) begin
         p3_round = cfg.model_select ? 8'd255 : 8'd127;
      end
      if (s2_p4_ff[42]) begin
         p4_round = cfg.model_select ? 8'd127 : 8'd63;
      end
      p6_round = s2_p6_ff[42] ? 23'h7F_FFFF : 23'd0;
   end

   assign p3_adj = s2_p3_ff + $signed({35'd0, p3_round});
   assign p4_adj = s2_p4_ff + $signed({35'd0, p4_round});
   assign p6_adj = s2_p6_ff + $signed({20'd0, p6_round});
   assign q3     = cfg.model_select ? (p3_adj >>> 8) : (p3_adj >>> 7);
   assign q4     = cfg.model_select ? (p4_adj >>> 7) : (p4_adj >>> 6);

   // squared difference is never negative, so its scalings are plain shifts
   assign sq_w   = {4'd0, s2_sq_ff};
   assign sq_x11 = (sq_w << 3) + (sq_w << 1) + sq_w;
   assign sq_x3  = (sq_w << 1) + sq_w;

   always_comb begin
      s3_in.d1    = s2_d1_ff;
      s3_in.sens1 = $signed(cfg.model_select ? {9'd0, cfg.pressure_sens, 15'd0}
                                             : {8'd0, cfg.pressure_sens, 16'd0})
                  + $signed(q3[39:0]);
      s3_in.off1  = $signed(cfg.model_select ? {8'd0, cfg.pressure_offset, 16'd0}
                                             : {7'd0, cfg.pressure_offset, 17'd0})
                  + $signed(q4[39:0]);
      s3_in.dev   = $signed(p6_adj[42:23]);
      s3_in.lo    = $signed(p6_adj[42:23]) + $signed(20'(VERY_LOW_OFFSET));
      s3_in.ti_low  = cfg.model_select ? sq_x3[52:33] : sq_x11[54:35];
      s3_in.ti_high = sq_w[55:36];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_d1_ff <= s1_d1_in;
         s1_dt_ff <= s1_dt_in;
         s2_d1_ff <= s1_d1_ff;
         s2_p3_ff <= s2_p3_in;
         s2_p4_ff <= s2_p4_in;
         s2_p6_ff <= s2_p6_in;
         s2_sq_ff <= s2_sq_in;
         s3_ff    <= s3_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_ff;

endmodule

@@ rtl/psc_second.sv @@
// Second-order correction: squared deviations, corrected offset, sensitivity, temperature
`timescale 1ns / 1ps
`include "pressure_sensor_compensation_assert.svh"
module psc_second
   import psc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  cfg_type   cfg,
   input  logic      in_valid,
   input  front_type in_data,
   output logic      out_valid,
   output corr_type  out_data
);

   // stage 4
   logic               s4_valid_ff;
   logic [23:0]        s4_d1_ff;
   logic signed [39:0] s4_sens1_ff, s4_off1_ff;
   logic signed [31:0] s4_temp_ff, s4_temp_in;
   logic [39:0]        s4_dev2_ff, s4_dev2_in;
   logic [39:0]        s4_lo2_ff, s4_lo2_in;
   logic               s4_low_ff, s4_vlow_ff;
   // stage 5
   logic               s5_valid_ff;
   corr_type           s5_ff, s5_in;

   logic [19:0]        ti_sel;
   logic [39:0]        offi, sensi, lo_off, lo_sens;

   // below the base temperature exactly when the deviation is negative
   always_comb begin
      ti_sel = 20'd0;
      if (in_data.dev[19]) begin
         ti_sel = in_data.ti_low;
      end else if (cfg.model_select) begin
         ti_sel = in_data.ti_high;
      end
   end

   assign s4_temp_in = $signed({{12{in_data.dev[19]}}, in_data.dev})
                     + $signed(32'(TEMP_BASE))
                     - $signed({12'd0, ti_sel});
   assign s4_dev2_in = in_data.dev * in_data.dev;
   assign s4_lo2_in  = in_data.lo * in_data.lo;

   assign lo_off  = s4_vlow_ff ? ((s4_lo2_ff << 3) - s4_lo2_ff) : 40'd0;
   assign lo_sens = s4_vlow_ff ? (s4_lo2_ff << 2) : 40'd0;

   always_comb begin
      offi  = 40'd0;
      sensi = 40'd0;
      if (!cfg.model_select) begin
         if (s4_low_ff) begin
            offi  = ((s4_dev2_ff << 5) - s4_dev2_ff) >> 3;
            sensi = ((s4_dev2_ff << 6) - s4_dev2_ff) >> 5;
         end
      end else if (s4_low_ff) begin
         offi  = (((s4_dev2_ff << 1) + s4_dev2_ff) >> 1) + lo_off;
         sensi = (((s4_dev2_ff << 2) + s4_dev2_ff) >> 3) + lo_sens;
      end else begin
         offi  = s4_dev2_ff >> 4;
      end
   end

   always_comb begin
      s5_in.d1   = s4_d1_ff;
      s5_in.sens = s4_sens1_ff - $signed(sensi);
      s5_in.off  = s4_off1_ff - $signed(offi);
      s5_in.temp = s4_temp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= in_valid;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_d1_ff    <= in_data.d1;
         s4_sens1_ff <= in_data.sens1;
         s4_off1_ff  <= in_data.off1;
         s4_temp_ff  <= s4_temp_in;
         s4_dev2_ff  <= s4_dev2_in;
         s4_lo2_ff   <= s4_lo2_in;
         s4_low_ff   <= in_data.dev[19];
         s4_vlow_ff  <= in_data.lo[19];
         s5_ff       <= s5_in;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_data  = s5_ff;

   // the base variant leaves warm readings uncorrected
   `PSC_ASSERT_IMPL(warm_base_uncorrected_a, clock, reset, s4_valid_ff && !cfg.model_select && !s4_low_ff, offi == 40'd0 && sensi == 40'd0)

endmodule

@@ rtl/psc_pressure.sv @@
// Back end: split pressure product, scaling, final divide and saturation
`timescale 1ns / 1ps
module psc_pressure
   import psc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  cfg_type  cfg,
   input  logic     in_valid,
   input  corr_type in_data,
   output logic     out_valid,
   output rsp_type  out_data
);

   // stage 6
   logic               s6_valid_ff;
   logic [43:0]        s6_pp_lo_ff, s6_pp_lo_in;
   logic signed [44:0] s6_pp_hi_ff, s6_pp_hi_in;
   logic signed [39:0] s6_off_ff;
   logic signed [31:0] s6_temp_ff;
   // stage 7
   logic               s7_valid_ff;
   logic signed [44:0] s7_q_ff, s7_q_in;
   logic signed [39:0] s7_off_ff;
   logic signed [31:0] s7_temp_ff;
   // stage 8
   logic               s8_valid_ff;
   logic signed [45:0] s8_num_ff, s8_num_in;
   logic signed [31:0] s8_temp_ff;
   // stage 9, output register
   logic               s9_valid_ff;
   rsp_type            s9_ff, s9_in;

   logic signed [65:0] prod, prod_adj;
   logic [20:0]        prod_round;
   logic [14:0]        num_round;
   logic signed [45:0] num_adj, quo;
   logic               sat_hi, sat_lo;

   // sensitivity split in two 20-bit halves to keep each multiplier narrow
   assign s6_pp_lo_in = in_data.d1 * in_data.sens[19:0];
   assign s6_pp_hi_in = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[39:20]);

   assign prod       = $signed({{1{s6_pp_hi_ff[44]}}, s6_pp_hi_ff, 20'd0})
                     + $signed({22'd0, s6_pp_lo_ff});
   assign prod_round = prod[65] ? 21'h1F_FFFF : 21'd0;
   assign prod_adj   = prod + $signed({45'd0, prod_round});
   assign s7_q_in    = $signed(prod_adj[65:21]);

   assign s8_num_in = $signed({s7_q_ff[44], s7_q_ff}) - $signed({{6{s7_off_ff[39]}}, s7_off_ff});

   always_comb begin
      num_round = 15'd0;
      if (s8_num_ff[45]) begin
         num_round = cfg.model_select ? 15'h1FFF : 15'h7FFF;
      end
   end

   assign num_adj = s8_num_ff + $signed({31'd0, num_round});
   assign quo     = cfg.model_select ? (num_adj >>> 13) : (num_adj >>> 15);
   assign sat_hi  = !quo[45] && (quo[44:31] != 14'h0000);
   assign sat_lo  = quo[45] && (quo[44:31] != 14'h3FFF);

   always_comb begin
      s9_in.temperature = s8_temp_ff;
      if (sat_hi) begin
         s9_in.pressure = $signed(SAT_MAX);
      end else if (sat_lo) begin
         s9_in.pressure = $signed(SAT_MIN);
      end else begin
         s9_in.pressure = $signed(quo[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
         s9_valid_ff <= 1'b0;
      end else if (advance) begin
         s6_valid_ff <= in_valid;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= s7_valid_ff;
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s6_pp_lo_ff <= s6_pp_lo_in;
         s6_pp_hi_ff <= s6_pp_hi_in;
         s6_off_ff   <= in_data.off;
         s6_temp_ff  <= in_data.temp;
         s7_q_ff     <= s7_q_in;
         s7_off_ff   <= s6_off_ff;
         s7_temp_ff  <= s6_temp_ff;
         s8_num_ff   <= s8_num_in;
         s8_temp_ff  <= s7_temp_ff;
         s9_ff       <= s9_in;
      end
   end

   assign out_valid = s9_valid_ff;
   assign out_data  = s9_ff;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the pressure compensation pipeline, with random calibration sets
module tb;
   import psc_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          DRAIN_CYCLES = 20;   // pipeline is nine stages deep
   localparam logic [23:0] RAW_MAX      = 24'hFF_FFFF;
   localparam longint      VERY_LOW_TEMP = -1500;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   cfg_type cal = '0;
   req_type raw_queue[$];
   rsp_type expected_readings[$];
   bit      idle_on   = 1'b1;
   bit      req_taken = 1'b0;
   bit      rsp_taken = 1'b0;
   int      req_gap   = 0;
   int      rsp_hold  = 0;
   int      mismatches = 0;
   int      cycle_count = 0;

   pressure_sensor_compensation DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic signed [31:0] sat32(input longint v);
      if (v > 64'sd2147483647) return SAT_MAX;
      if (v < -64'sd2147483648) return SAT_MIN;
      return v[31:0];
   endfunction

   // 64-bit signed arithmetic throughout; SV division truncates toward zero
   function automatic rsp_type compensate(input req_type r);
      longint  d1, dt, dt2, sens, off, divisor, temp, ti, offi, sensi, dev, dev2, lo;
      rsp_type res;
      d1   = longint'(r.raw_pressure);
      dt   = longint'(r.raw_temperature) - longint'(cal.reference_temp) * 256;
      dt2  = dt * dt;
      ti   = 0;
      offi = 0;
      sensi = 0;
      if (!cal.model_select) begin
         sens    = longint'(cal.pressure_sens) * 65536 + longint'(cal.sens_temp_coeff) * dt / 128;
         off     = longint'(cal.pressure_offset) * 131072
                   + longint'(cal.offset_temp_coeff) * dt / 64;
         divisor = 32768;
      end else begin
         sens    = longint'(cal.pressure_sens) * 32768 + longint'(cal.sens_temp_coeff) * dt / 256;
         off     = longint'(cal.pressure_offset) * 65536
                   + longint'(cal.offset_temp_coeff) * dt / 128;
         divisor = 8192;
      end
      temp = TEMP_BASE + dt * longint'(cal.temp_coeff) / 8388608;
      dev  = temp - TEMP_BASE;
      dev2 = dev * dev;
      if (!cal.model_select) begin
         // variant 0 corrects only below the base temperature
         if (temp < TEMP_BASE) begin
            ti    = 11 * dt2 / 64'sd34359738368;
            offi  = 31 * dev2 / 8;
            sensi = 63 * dev2 / 32;
         end
      end else if (temp < TEMP_BASE) begin
         ti    = 3 * dt2 / 64'sd8589934592;
         offi  = 3 * dev2 / 2;
         sensi = 5 * dev2 / 8;
         if (temp < VERY_LOW_TEMP) begin
            lo    = temp - VERY_LOW_TEMP;
            offi  = offi + 7 * lo * lo;
            sensi = sensi + 4 * lo * lo;
         end
      end else begin
         ti   = 2 * dt2 / 64'sd137438953472;
         offi = dev2 / 16;
      end
      sens = sens - sensi;
      off  = off - offi;
      temp = temp - ti;
      res.pressure    = sat32((d1 * sens / 2097152 - off) / divisor);
      res.temperature = sat32(temp);
      return res;
   endfunction

   // half the raw temperatures land near the reference point so every branch gets hit
   function automatic req_type random_raw();
      req_type r;
      int      near;
      r.raw_pressure = 24'($urandom);
      if ($urandom_range(0, 1)) begin
         r.raw_temperature = 24'($urandom);
      end else begin
         near = int'(cal.reference_temp) * 256 + int'($urandom_range(0, 1 << 22)) - (1 << 21);
         if (near < 0) near = 0;
         if (near > int'(RAW_MAX)) near = int'(RAW_MAX);
         r.raw_temperature = near[23:0];
      end
      return r;
   endfunction

   task automatic push_raw(input logic [23:0] d1, input logic [23:0] d2);
      raw_queue.push_back('{raw_pressure: d1, raw_temperature: d2});
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MODEL_SELECT:      cal.model_select      = val[0];
         CSR_PRESSURE_SENS:     cal.pressure_sens     = val;
         CSR_PRESSURE_OFFSET:   cal.pressure_offset   = val;
         CSR_SENS_TEMP_COEFF:   cal.sens_temp_coeff   = val;
         CSR_OFFSET_TEMP_COEFF: cal.offset_temp_coeff = val;
         CSR_REFERENCE_TEMP:    cal.reference_temp    = val;
         CSR_TEMP_COEFF:        cal.temp_coeff        = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_cal(input cfg_type c);
      // upper bits of the model select word must be dropped
      write_csr(CSR_MODEL_SELECT, {15'($urandom), c.model_select});
      write_csr(CSR_PRESSURE_SENS, c.pressure_sens);
      write_csr(CSR_PRESSURE_OFFSET, c.pressure_offset);
      write_csr(CSR_SENS_TEMP_COEFF, c.sens_temp_coeff);
      write_csr(CSR_OFFSET_TEMP_COEFF, c.offset_temp_coeff);
      write_csr(CSR_REFERENCE_TEMP, c.reference_temp);
      write_csr(CSR_TEMP_COEFF, c.temp_coeff);
      write_csr(CSR_UNUSED, 16'($urandom));
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (raw_queue.size() != 0 || req_valid || expected_readings.size() != 0);
   endtask

   task automatic run_random(input int count);
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (count) raw_queue.push_back(random_raw());
      wait_drained();
   endtask

   // driver: inputs move on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_valid <= 1'b0;
            end else if (raw_queue.size() > 0) begin
               req_data  <= raw_queue.pop_front();
               req_valid <= 1'b1;
               req_gap = idle_on ? $urandom_range(0, 3) : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (rsp_taken) rsp_hold = idle_on ? $urandom_range(0, 3) : 0;
         rsp_stall <= (rsp_hold > 0);
         if (rsp_hold > 0) rsp_hold = rsp_hold - 1;
      end
   end

   // monitor: transfers sampled on the rising edge
   always @(posedge clock) begin
      rsp_type want;
      req_taken <= !reset && req_valid && !req_stall;
      rsp_taken <= !reset && rsp_valid && !rsp_stall;
      if (!reset && req_valid && !req_stall) expected_readings.push_back(compensate(req_data));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            $error("unexpected result: pressure %0d temperature %0d",
                   rsp_data.pressure, rsp_data.temperature);
            mismatches++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_data.pressure !== want.pressure) begin
               $error("pressure: expected %0d, got %0d", want.pressure, rsp_data.pressure);
               mismatches++;
            end
            if (rsp_data.temperature !== want.temperature) begin
               $error("temperature: expected %0d, got %0d",
                      want.temperature, rsp_data.temperature);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      cfg_type      typical, c;
      logic [127:0] raw_cal;
      typical = '{model_select: 1'b1, pressure_sens: 16'd34982, pressure_offset: 16'd36352,
                  sens_temp_coeff: 16'd20328, offset_temp_coeff: 16'd22354,
                  reference_temp: 16'd26646, temp_coeff: 16'd26146};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // calibration still at its reset values
      push_raw(24'd0, 24'd0);
      push_raw(RAW_MAX, RAW_MAX);
      push_raw(RAW_MAX, 24'd0);
      wait_drained();

      // typical factory words, variant 1: boundaries of each temperature band
      program_cal(typical);
      push_raw(24'd0, 24'd0);
      push_raw(RAW_MAX, RAW_MAX);
      push_raw(RAW_MAX, 24'd0);
      push_raw(24'd0, RAW_MAX);
      push_raw(24'd8500000, 24'd6821376);
      push_raw(24'd8500000, 24'd6821375);
      push_raw(24'd8500000, 24'd6000000);
      push_raw(24'd8500000, 24'd5700000);
      push_raw(24'd8500000, 24'd5000000);
      push_raw(24'd8500000, 24'd9000000);
      wait_drained();
      run_random(100);

      typical.model_select = 1'b0;
      program_cal(typical);
      run_random(100);

      // all words at full scale, both variants
      for (int m = 1; m >= 0; m--) begin
         c = '1;
         c.model_select = m[0];
         program_cal(c);
         push_raw(RAW_MAX, 24'd0);
         push_raw(24'd0, RAW_MAX);
         push_raw(RAW_MAX, 24'hFF_FF00);
         wait_drained();
         run_random(60);
      end

      c = '0;
      c.model_select = 1'b1;
      program_cal(c);
      run_random(40);

      repeat (7) begin
         raw_cal = {$urandom, $urandom, $urandom, $urandom};
         c = raw_cal[$bits(cfg_type)-1:0];
         program_cal(c);
         run_random(85);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/psc_pkg.sv
rtl/psc_front.sv
rtl/psc_second.sv
rtl/psc_pressure.sv
rtl/pressure_sensor_compensation.sv
bench/tb.sv
